>>> sv/qeyr_pkg.sv
// ---------------------------------------------------------------------------
// qeyr_pkg: shared types and constants of the quaternion Euler yaw core
// Holds the CORDIC arctangent table, the fixed-point constants, and the
// word that moves down the cell chain.
// ---------------------------------------------------------------------------
package qeyr_pkg;

    localparam int TAB_LEN = 24;
    localparam int ANG_W   = 36;
    localparam int VEC_W   = 40;
    localparam int SQ_W    = 58;

    localparam logic signed [ANG_W-1:0] HALF_PI_30  = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_30       = 36'sd3373259426;
    localparam logic signed [VEC_W-1:0] GAIN_INV_30 = 40'sd652032874;
    localparam logic signed [VEC_W-1:0] ONE_28      = 40'sd268435456;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    function automatic ang_t atan_entry(input int idx);
        ang_t r;
        case (idx)
            0: r = 36'sh03243F6A8;
            1: r = 36'sh01DAC6705;
            2: r = 36'sh00FADBAFC;
            3: r = 36'sh007F56EA6;
            4: r = 36'sh003FEAB76;
            5: r = 36'sh001FFD55B;
            6: r = 36'sh000FFFAAA;
            7: r = 36'sh0007FFF55;
            8: r = 36'sh0003FFFEA;
            9: r = 36'sh0001FFFFD;
            10: r = 36'sh0000FFFFF;
            11: r = 36'sh00007FFFF;
            12: r = 36'sh00003FFFF;
            13: r = 36'sh00001FFFF;
            14: r = 36'sh00000FFFF;
            15: r = 36'sh000007FFF;
            16: r = 36'sh000003FFF;
            17: r = 36'sh000001FFF;
            18: r = 36'sh000000FFF;
            19: r = 36'sh0000007FF;
            20: r = 36'sh0000003FF;
            21: r = 36'sh0000001FF;
            22: r = 36'sh0000000FF;
            23: r = 36'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

    // One vectoring CORDIC lane: x, y, accumulated angle.
    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
    } vlane_t;

    // One rotation CORDIC lane.
    typedef struct packed {
        vec_t x;
        vec_t y;
        ang_t z;
        logic neg;
    } rlane_t;

endpackage

>>> sv/qeyr_vec_cell.sv
// ---------------------------------------------------------------------------
// qeyr_vec_cell: one vectoring CORDIC micro-rotation
// Turns the vector toward the x axis by atan(2^-STEP) and accumulates it.
// ---------------------------------------------------------------------------
module qeyr_vec_cell #(
    parameter int STEP = 0
) (
    input  qeyr_pkg::vlane_t din,
    output qeyr_pkg::vlane_t dout
);
    qeyr_pkg::vec_t dx;
    qeyr_pkg::vec_t dy;

    assign dx = din.y >>> STEP;
    assign dy = din.x >>> STEP;

    always_comb
    begin
        if (din.y[qeyr_pkg::VEC_W-1])
        begin
            dout.x = din.x - dx;
            dout.y = din.y + dy;
            dout.z = din.z - qeyr_pkg::atan_entry(STEP);
        end
        else
        begin
            dout.x = din.x + dx;
            dout.y = din.y - dy;
            dout.z = din.z + qeyr_pkg::atan_entry(STEP);
        end
    end
endmodule

>>> sv/qeyr_rot_cell.sv
// ---------------------------------------------------------------------------
// qeyr_rot_cell: one rotation CORDIC micro-rotation
// Turns the vector by atan(2^-STEP) toward the residual angle.
// ---------------------------------------------------------------------------
module qeyr_rot_cell #(
    parameter int STEP = 0
) (
    input  qeyr_pkg::rlane_t din,
    output qeyr_pkg::rlane_t dout
);
    qeyr_pkg::vec_t dx;
    qeyr_pkg::vec_t dy;

    assign dx = din.y >>> STEP;
    assign dy = din.x >>> STEP;

    always_comb
    begin
        dout.neg = din.neg;
        if (!din.z[qeyr_pkg::ANG_W-1])
        begin
            dout.x = din.x - dx;
            dout.y = din.y + dy;
            dout.z = din.z - qeyr_pkg::atan_entry(STEP);
        end
        else
        begin
            dout.x = din.x + dx;
            dout.y = din.y - dy;
            dout.z = din.z + qeyr_pkg::atan_entry(STEP);
        end
    end
endmodule

>>> sv/qeyr_isqrt_cell.sv
// ---------------------------------------------------------------------------
// qeyr_isqrt_cell: one step of the restoring integer square root
// Resolves two radicand bits per cell at bit weight 4^BITPOS.
// ---------------------------------------------------------------------------
module qeyr_isqrt_cell #(
    parameter int BITPOS = 0
) (
    input  logic [qeyr_pkg::SQ_W-1:0] n_in,
    input  logic [qeyr_pkg::SQ_W-1:0] r_in,
    output logic [qeyr_pkg::SQ_W-1:0] n_out,
    output logic [qeyr_pkg::SQ_W-1:0] r_out
);
    localparam logic [qeyr_pkg::SQ_W-1:0] BIT_VAL =
        qeyr_pkg::SQ_W'(1) << (2 * BITPOS);
    logic [qeyr_pkg::SQ_W-1:0] trial;

    assign trial = r_in + BIT_VAL;

    always_comb
    begin
        if (n_in >= trial)
        begin
            n_out = n_in - trial;
            r_out = (r_in >> 1) + BIT_VAL;
        end
        else
        begin
            n_out = n_in;
            r_out = r_in >> 1;
        end
    end
endmodule

>>> sv/quaternion_to_euler_yaw_rotation_core.sv
// ---------------------------------------------------------------------------
// Flow: an accepted input word passes through every registered stage in turn to its
// output word. Throughput: one word per cycle; a stalled output only halts
// the chain, and all cells advance together when the output slot frees.
// Reset: rst_n clears all valid bits asynchronously; data needs no reset.
// ---------------------------------------------------------------------------
// quaternion_to_euler_yaw_rotation_core: ZYX Euler angles and yaw rotation
// A row of registered CORDIC and square-root cells turns a Q1.14 quaternion
// into roll and yaw in Q3.13, pitch in Q1.13, and cosine and sine of yaw in Q1.14.
// ---------------------------------------------------------------------------
module quaternion_to_euler_yaw_rotation_core #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic signed [15:0] yaw_cosine,
    output logic signed [15:0] yaw_sine,
    output logic               pitch_saturated
);
    localparam int N      = CORDIC_ITERATIONS;
    localparam int SQ_N   = 29;          // root bits resolved, 2 radicand bits each
    // Stage plan: 1 products, 1 sums, SQ_N root cells, 1 quadrant fold,
    // N vectoring cells, 1 angle rounding, 1 rotation setup, N rotation cells,
    // 1 output rounding. Roll and yaw ride alongside the pitch root.
    localparam int S_PROD = 0;
    localparam int S_SUM  = 1;
    localparam int S_SQ0  = 2;
    localparam int S_FOLD = S_SQ0 + SQ_N;
    localparam int S_VEC0 = S_FOLD + 1;
    localparam int S_ANG  = S_VEC0 + N;
    localparam int S_RSET = S_ANG + 1;
    localparam int S_ROT0 = S_RSET + 1;
    localparam int S_OUT  = S_ROT0 + N;
    localparam int DEPTH  = S_OUT + 1;

    typedef logic signed [qeyr_pkg::VEC_W-1:0] v_t;
    typedef logic signed [qeyr_pkg::ANG_W-1:0] a_t;

    // The whole chain advances together; it moves whenever the output slot
    // is empty or being drained.
    logic adv;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    assign adv      = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready = adv;
    assign vld_next = {vld_reg[DEPTH-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // ---------------- products ----------------
    logic signed [31:0] p_ww_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [31:0] p_wx_reg, p_yz_reg, p_wy_reg, p_xz_reg, p_wz_reg, p_xy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_ww_reg <= quat_w * quat_w;
            p_xx_reg <= quat_x * quat_x;
            p_yy_reg <= quat_y * quat_y;
            p_zz_reg <= quat_z * quat_z;
            p_wx_reg <= quat_w * quat_x;
            p_yz_reg <= quat_y * quat_z;
            p_wy_reg <= quat_w * quat_y;
            p_xz_reg <= quat_x * quat_z;
            p_wz_reg <= quat_w * quat_z;
            p_xy_reg <= quat_x * quat_y;
        end
    end

    // ---------------- sums and asin argument clamp ----------------
    v_t ry_reg, rx_reg, yy_reg, yx_reg, s_reg;
    logic flag_reg;
    v_t s_raw;
    always_comb
    begin
        s_raw = (v_t'(p_wy_reg) - v_t'(p_xz_reg)) <<< 1;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ry_reg <= (v_t'(p_wx_reg) + v_t'(p_yz_reg)) <<< 1;
            rx_reg <= v_t'(p_ww_reg) + v_t'(p_zz_reg) - v_t'(p_xx_reg) - v_t'(p_yy_reg);
            yy_reg <= (v_t'(p_wz_reg) + v_t'(p_xy_reg)) <<< 1;
            yx_reg <= v_t'(p_ww_reg) + v_t'(p_xx_reg) - v_t'(p_yy_reg) - v_t'(p_zz_reg);
            if (s_raw > qeyr_pkg::ONE_28)
            begin
                s_reg    <= qeyr_pkg::ONE_28;
                flag_reg <= 1'b1;
            end
            else if (s_raw < -qeyr_pkg::ONE_28)
            begin
                s_reg    <= -qeyr_pkg::ONE_28;
                flag_reg <= 1'b1;
            end
            else
            begin
                s_reg    <= s_raw;
                flag_reg <= 1'b0;
            end
        end
    end

    // ---------------- 1 - s^2 radicand and root cells ----------------
    // s^2 is at most 2^56: a 29x29 bit unsigned product.
    logic [28:0] mag;
    logic [qeyr_pkg::SQ_W-1:0] rad;
    assign mag = s_reg[39] ? 29'(-s_reg) : 29'(s_reg);
    assign rad = (qeyr_pkg::SQ_W'(1) << 56)
               - (qeyr_pkg::SQ_W'(mag) * qeyr_pkg::SQ_W'(mag));

    logic [qeyr_pkg::SQ_W-1:0] sqn_reg [SQ_N];
    logic [qeyr_pkg::SQ_W-1:0] sqr_reg [SQ_N];
    v_t sq_s_reg  [SQ_N];
    v_t sq_ry_reg [SQ_N], sq_rx_reg [SQ_N], sq_yy_reg [SQ_N], sq_yx_reg [SQ_N];
    logic sq_f_reg [SQ_N];

    genvar g;
    generate
        for (g = 0; g < SQ_N; g++)
        begin : g_sq
            logic [qeyr_pkg::SQ_W-1:0] n_i, r_i, n_o, r_o;
            v_t s_i, ry_i, rx_i, yy_i, yx_i;
            logic f_i;
            if (g == 0)
            begin : g_first
                assign n_i  = rad;
                assign r_i  = '0;
                assign s_i  = s_reg;
                assign ry_i = ry_reg;
                assign rx_i = rx_reg;
                assign yy_i = yy_reg;
                assign yx_i = yx_reg;
                assign f_i  = flag_reg;
            end
            else
            begin : g_rest
                assign n_i  = sqn_reg[g-1];
                assign r_i  = sqr_reg[g-1];
                assign s_i  = sq_s_reg[g-1];
                assign ry_i = sq_ry_reg[g-1];
                assign rx_i = sq_rx_reg[g-1];
                assign yy_i = sq_yy_reg[g-1];
                assign yx_i = sq_yx_reg[g-1];
                assign f_i  = sq_f_reg[g-1];
            end
            qeyr_isqrt_cell #(.BITPOS(SQ_N - 1 - g)) u_cell (
                .n_in (n_i),
                .r_in (r_i),
                .n_out(n_o),
                .r_out(r_o)
            );
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sqn_reg[g]   <= n_o;
                    sqr_reg[g]   <= r_o;
                    sq_s_reg[g]  <= s_i;
                    sq_ry_reg[g] <= ry_i;
                    sq_rx_reg[g] <= rx_i;
                    sq_yy_reg[g] <= yy_i;
                    sq_yx_reg[g] <= yx_i;
                    sq_f_reg[g]  <= f_i;
                end
            end
        end
    endgenerate

    // ---------------- quadrant fold for the three vectoring lanes ----------------
    function automatic qeyr_pkg::vlane_t fold(input v_t y, input v_t x);
        qeyr_pkg::vlane_t l;
        l.x = x;
        l.y = y;
        l.z = '0;
        if (x[qeyr_pkg::VEC_W-1])
        begin
            if (!y[qeyr_pkg::VEC_W-1])
            begin
                l.x = y;
                l.y = -x;
                l.z = qeyr_pkg::HALF_PI_30;
            end
            else
            begin
                l.x = -y;
                l.y = x;
                l.z = -qeyr_pkg::HALF_PI_30;
            end
        end
        return l;
    endfunction

    qeyr_pkg::vlane_t vr_reg [N+1];
    qeyr_pkg::vlane_t vp_reg [N+1];
    qeyr_pkg::vlane_t vy_reg [N+1];
    logic vz_r_reg [N+1];
    logic vz_y_reg [N+1];
    logic vf_reg   [N+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vr_reg[0]   <= fold(sq_ry_reg[SQ_N-1], sq_rx_reg[SQ_N-1]);
            vp_reg[0]   <= fold(sq_s_reg[SQ_N-1], v_t'(sqr_reg[SQ_N-1]));
            vy_reg[0]   <= fold(sq_yy_reg[SQ_N-1], sq_yx_reg[SQ_N-1]);
            vz_r_reg[0] <= (sq_ry_reg[SQ_N-1] == '0) && (sq_rx_reg[SQ_N-1] == '0);
            vz_y_reg[0] <= (sq_yy_reg[SQ_N-1] == '0) && (sq_yx_reg[SQ_N-1] == '0);
            vf_reg[0]   <= sq_f_reg[SQ_N-1];
        end
    end

    generate
        for (g = 0; g < N; g++)
        begin : g_vec
            qeyr_pkg::vlane_t r_o, p_o, y_o;
            qeyr_vec_cell #(.STEP(g)) u_r (.din(vr_reg[g]), .dout(r_o));
            qeyr_vec_cell #(.STEP(g)) u_p (.din(vp_reg[g]), .dout(p_o));
            qeyr_vec_cell #(.STEP(g)) u_y (.din(vy_reg[g]), .dout(y_o));
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    vr_reg[g+1]   <= r_o;
                    vp_reg[g+1]   <= p_o;
                    vy_reg[g+1]   <= y_o;
                    vz_r_reg[g+1] <= vz_r_reg[g];
                    vz_y_reg[g+1] <= vz_y_reg[g];
                    vf_reg[g+1]   <= vf_reg[g];
                end
            end
        end
    endgenerate

    // ---------------- angle rounding to Q3.13 with clamp ----------------
    function automatic logic signed [15:0] to_q13(input a_t z, input logic signed [15:0] lim);
        a_t q;
        q = (z + a_t'(65536)) >>> 17;
        if (q > a_t'(lim))
            return lim;
        else if (q < -a_t'(lim))
            return -lim;
        else
            return q[15:0];
    endfunction

    logic signed [15:0] roll_reg, pitch_reg, yaw_reg;
    logic f_ang_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            roll_reg  <= vz_r_reg[N] ? 16'sd0 : to_q13(vr_reg[N].z, 16'sd25736);
            pitch_reg <= to_q13(vp_reg[N].z, 16'sd12868);
            yaw_reg   <= vz_y_reg[N] ? 16'sd0 : to_q13(vy_reg[N].z, 16'sd25736);
            f_ang_reg <= vf_reg[N];
        end
    end

    // ---------------- rotation setup: fold yaw into +-pi/2 ----------------
    a_t theta;
    assign theta = a_t'(yaw_reg) <<< 17;

    qeyr_pkg::rlane_t rl_reg [N+1];
    logic signed [15:0] ro_roll_reg  [N+1];
    logic signed [15:0] ro_pitch_reg [N+1];
    logic signed [15:0] ro_yaw_reg   [N+1];
    logic ro_f_reg [N+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rl_reg[0].x <= qeyr_pkg::GAIN_INV_30;
            rl_reg[0].y <= '0;
            if (theta > qeyr_pkg::HALF_PI_30)
            begin
                rl_reg[0].z   <= theta - qeyr_pkg::PI_30;
                rl_reg[0].neg <= 1'b1;
            end
            else if (theta < -qeyr_pkg::HALF_PI_30)
            begin
                rl_reg[0].z   <= theta + qeyr_pkg::PI_30;
                rl_reg[0].neg <= 1'b1;
            end
            else
            begin
                rl_reg[0].z   <= theta;
                rl_reg[0].neg <= 1'b0;
            end
            ro_roll_reg[0]  <= roll_reg;
            ro_pitch_reg[0] <= pitch_reg;
            ro_yaw_reg[0]   <= yaw_reg;
            ro_f_reg[0]     <= f_ang_reg;
        end
    end

    generate
        for (g = 0; g < N; g++)
        begin : g_rot
            qeyr_pkg::rlane_t o;
            qeyr_rot_cell #(.STEP(g)) u_c (.din(rl_reg[g]), .dout(o));
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rl_reg[g+1]       <= o;
                    ro_roll_reg[g+1]  <= ro_roll_reg[g];
                    ro_pitch_reg[g+1] <= ro_pitch_reg[g];
                    ro_yaw_reg[g+1]   <= ro_yaw_reg[g];
                    ro_f_reg[g+1]     <= ro_f_reg[g];
                end
            end
        end
    endgenerate

    // ---------------- output rounding, sign restore, clamp ----------------
    function automatic logic signed [15:0] to_q14(input v_t v, input logic neg);
        v_t q;
        q = (v + v_t'(32768)) >>> 16;
        if (neg)
            q = -q;
        if (q > v_t'(16384))
            return 16'sd16384;
        else if (q < -v_t'(16384))
            return -16'sd16384;
        else
            return q[15:0];
    endfunction

    logic signed [15:0] o_roll_reg, o_yaw_reg, o_cos_reg, o_sin_reg;
    logic signed [14:0] o_pitch_reg;
    logic o_f_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_roll_reg  <= ro_roll_reg[N];
            o_pitch_reg <= ro_pitch_reg[N][14:0];
            o_yaw_reg   <= ro_yaw_reg[N];
            o_cos_reg   <= to_q14(rl_reg[N].x, rl_reg[N].neg);
            o_sin_reg   <= to_q14(rl_reg[N].y, rl_reg[N].neg);
            o_f_reg     <= ro_f_reg[N];
        end
    end

    assign out_valid       = vld_reg[DEPTH-1];
    assign roll_angle      = o_roll_reg;
    assign pitch_angle     = o_pitch_reg;
    assign yaw_angle       = o_yaw_reg;
    assign yaw_cosine      = o_cos_reg;
    assign yaw_sine        = o_sin_reg;
    assign pitch_saturated = o_f_reg;

endmodule

>>> sv/qeyr_checker.sv
// ---------------------------------------------------------------------------
// qeyr_checker: port-level checks of the quaternion Euler yaw core
// Watches the handshakes and the range of the yaw cosine and sine words.
// ---------------------------------------------------------------------------
module qeyr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] roll_angle,
    input logic signed [15:0] yaw_cosine,
    input logic signed [15:0] yaw_sine
);
    // A held output word stays valid, and its roll angle stays put, until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roll_angle))
        else $error("output word changed while stalled");

    // The core never refuses input while its output slot is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with empty output slot");

    // Rotation entries stay within unit magnitude.
    a_trig: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> yaw_cosine <= 16'sd16384 && yaw_cosine >= -16'sd16384
                      && yaw_sine <= 16'sd16384 && yaw_sine >= -16'sd16384)
        else $error("rotation entry out of range");

    // Stall on output stalls the input side too.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");
endmodule

bind quaternion_to_euler_yaw_rotation_core qeyr_checker u_qeyr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .roll_angle(roll_angle),
    .yaw_cosine(yaw_cosine),
    .yaw_sine  (yaw_sine)
);

>>> test/quaternion_to_euler_yaw_rotation_core_tb.sv
// ---------------------------------------------------------------------------
// quaternion_to_euler_yaw_rotation_core_tb: self-checking bench of the core
// Feeds quaternion words through the valid/ready input and compares every
// output word, field by field, with angles and yaw trig computed here in
// 64-bit integer arithmetic. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module quaternion_to_euler_yaw_rotation_core_tb;

    localparam int ITERS       = 16;
    localparam int LATENCY     = 2 * ITERS + 35;
    localparam int CYCLE_LIMIT = 200000;

    // One expected output word.
    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] cosv;
        logic signed [15:0] sinv;
        logic               sat;
    } euler_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] yaw_cosine;
    logic signed [15:0] yaw_sine;
    logic               pitch_saturated;

    int  mismatches;
    int  cycle_count;
    bit  quiet_phase;   // when set, neither side idles
    bit  stim_done;

    quaternion_to_euler_yaw_rotation_core #(
        .CORDIC_ITERATIONS(ITERS)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .yaw_cosine(yaw_cosine), .yaw_sine(yaw_sine),
        .pitch_saturated(pitch_saturated)
    );

    // Arctangent of 2^-i in radians scaled by 2^30.
    function automatic longint atan_step(int i);
        longint steps [24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
            64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
            64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
            64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
            64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        return steps[i];
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // Vectoring CORDIC: angle of (x, y) scaled by 2^30.
    function automatic longint cordic_angle(longint y, longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = longint'(qeyr_pkg::HALF_PI_30);
            end
            else begin
                x = -y; y = t; z = -longint'(qeyr_pkg::HALF_PI_30);
            end
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint angle_q13(longint z);
        return (z + 65536) >>> 17;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Euler angles and yaw rotation of one quaternion.
    function automatic euler_t euler_of(logic signed [15:0] qx, logic signed [15:0] qy,
                                        logic signed [15:0] qz, logic signed [15:0] qw);
        euler_t  e;
        longint  x, y, z, w, s, mag, th, cx, sy, dx, dy, v;
        bit      neg;
        x = qx; y = qy; z = qz; w = qw;
        neg = 0;
        e.sat = 0;
        v = clip(angle_q13(cordic_angle((w*x + y*z) * 2, w*w + z*z - x*x - y*y)), 25736);
        e.roll = v[15:0];
        s = (w*y - x*z) * 2;
        if (s > longint'(qeyr_pkg::ONE_28)) begin
            s = longint'(qeyr_pkg::ONE_28); e.sat = 1;
        end
        if (s < -longint'(qeyr_pkg::ONE_28)) begin
            s = -longint'(qeyr_pkg::ONE_28); e.sat = 1;
        end
        mag = (s < 0) ? -s : s;
        v = floor_sqrt((64'd1 << 56) - longint'(mag) * longint'(mag));
        v = clip(angle_q13(cordic_angle(s, v)), 12868);
        e.pitch = v[14:0];
        v = clip(angle_q13(cordic_angle((w*z + x*y) * 2, w*w + x*x - y*y - z*z)), 25736);
        e.yaw = v[15:0];
        // The rotation angle is folded into +-pi/2 and the result negated when it was folded.
        th = v * 131072;
        if (th > longint'(qeyr_pkg::HALF_PI_30)) begin
            th -= longint'(qeyr_pkg::PI_30); neg = 1;
        end
        else if (th < -longint'(qeyr_pkg::HALF_PI_30)) begin
            th += longint'(qeyr_pkg::PI_30); neg = 1;
        end
        cx = longint'(qeyr_pkg::GAIN_INV_30);
        sy = 0;
        for (int i = 0; i < ITERS; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (th >= 0) begin
                cx -= dx; sy += dy; th -= atan_step(i);
            end
            else begin
                cx += dx; sy -= dy; th += atan_step(i);
            end
        end
        cx = (cx + 32768) >>> 16;
        sy = (sy + 32768) >>> 16;
        if (neg) begin
            cx = -cx; sy = -sy;
        end
        cx = clip(cx, 16384);
        sy = clip(sy, 16384);
        e.cosv = cx[15:0];
        e.sinv = sy[15:0];
        return e;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Holds the angles still owed by the core, oldest first.
    class euler_board;
        euler_t pending[$];

        function void note_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                                logic signed [15:0] qz, logic signed [15:0] qw);
            pending.push_back(euler_of(qx, qy, qz, qw));
        endfunction

        task check_word(euler_t got);
            euler_t want;
            if (pending.size() == 0) begin
                $display("output word with nothing outstanding");
                mismatches++;
            end
            else begin
                want = pending.pop_front();
                if (got.roll !== want.roll)   report("roll", got.roll, want.roll);
                if (got.pitch !== want.pitch) report("pitch", got.pitch, want.pitch);
                if (got.yaw !== want.yaw)     report("yaw", got.yaw, want.yaw);
                if (got.cosv !== want.cosv)   report("cosine", got.cosv, want.cosv);
                if (got.sinv !== want.sinv)   report("sine", got.sinv, want.sinv);
                if (got.sat !== want.sat)     report("saturated", got.sat, want.sat);
            end
        endtask
    endclass

    euler_board board = new();

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Drive one word, holding it until the core takes it. Valid stays high
    // straight into the next word when there is no idle cycle.
    task automatic send_quat(int qx, int qy, int qz, int qw);
        while (!quiet_phase && $urandom_range(99) < 10) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        quat_x <= 16'(qx); quat_y <= 16'(qy); quat_z <= 16'(qz); quat_w <= 16'(qw);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_quat(16'(qx), 16'(qy), 16'(qz), 16'(qw));
    endtask

    function automatic int rand_comp();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $signed($urandom_range(32768)) - 16384;
        if (r < 85)
            return int'($signed(16'($urandom)));
        return $urandom_range(1) ? 16384 : -16384;
    endfunction

    // Random unit-length quaternion, built from a random direction scaled.
    task automatic send_unit();
        real a, b, c, d, n;
        a = $itor($signed($urandom_range(20000))) - 10000.0;
        b = $itor($signed($urandom_range(20000))) - 10000.0;
        c = $itor($signed($urandom_range(20000))) - 10000.0;
        d = $itor($signed($urandom_range(20000))) - 10000.0;
        n = $sqrt(a*a + b*b + c*c + d*d);
        if (n < 1.0)
            n = 1.0;
        send_quat($rtoi(a/n*16384.0), $rtoi(b/n*16384.0),
                  $rtoi(c/n*16384.0), $rtoi(d/n*16384.0));
    endtask

    // Output side: random stalls, checks each accepted word.
    always @(posedge clk) begin
        euler_t got;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                got.roll = roll_angle;  got.pitch = pitch_angle;
                got.yaw = yaw_angle;    got.cosv = yaw_cosine;
                got.sinv = yaw_sine;    got.sat = pitch_saturated;
                board.check_word(got);
            end
            out_ready <= quiet_phase || ($urandom_range(99) >= 10);
        end
    end

    // Watchdog on total run length.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        mismatches = 0; cycle_count = 0; quiet_phase = 0; stim_done = 0;
        rst_n = 0; in_valid = 0; out_ready = 0;
        quat_x = 0; quat_y = 0; quat_z = 0; quat_w = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: identity, zero, extremes, pitch at and beyond +-1,
        // yaw near pi so that atan2 sees a negative x.
        send_quat(0, 0, 0, 16384);
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, -16384, 0);
        send_quat(-16384, -16384, -16384, -16384);
        send_quat(16384, 16384, 16384, 16384);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, -32768, 32767, -32768);
        send_quat(0, 11585, 0, 11585);      // pitch argument just below +1.0, no flag
        send_quat(0, -11585, 0, 11585);
        send_quat(0, 16384, 0, 16384);      // argument 2.0, clamped
        send_quat(16384, 0, 16384, 0);
        send_quat(0, 0, 11585, 11585);      // yaw +pi/2
        send_quat(0, 0, -11585, 11585);
        send_quat(0, 0, 15000, 6000);       // yaw beyond pi/2
        send_quat(0, 0, -15000, 6000);
        send_quat(-16384, 0, 0, 0);
        send_quat(21845, -10923, 4660, -17185);

        // Hold off until the pipeline drains completely.
        in_valid <= 0;
        while (board.pending.size() != 0)
            @(posedge clk);

        for (int k = 0; k < 900; k++) begin
            quiet_phase = (k >= 300 && k < 450);
            if (k == 600) begin
                in_valid <= 0;
                while (board.pending.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(99) < 60)
                send_unit();
            else
                send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
        in_valid <= 0;
        quiet_phase = 0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatches == 0 && board.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> quaternion_to_euler_yaw_rotation_core.f
sv/qeyr_pkg.sv
sv/qeyr_vec_cell.sv
sv/qeyr_rot_cell.sv
sv/qeyr_isqrt_cell.sv
sv/quaternion_to_euler_yaw_rotation_core.sv
sv/qeyr_checker.sv
test/quaternion_to_euler_yaw_rotation_core_tb.sv
